[hdl/cpsat_pkg.sv]
// Package for the convex polygon separating-axis overlap block.
// Holds sizes, item types, controller states and the command and status
// structs shared by the controller, the datapath and the top level.
package cpsat_pkg;

  // Capacity per polygon and internal coordinate width.
  localparam int MAX_VERTS = 16;
  localparam int COORD_BITS = 16;

  // Width of the coordinate fields on the input item.
  localparam int IN_W = 16;

  // Derived widths.
  localparam int IDX_W = $clog2(MAX_VERTS);
  localparam int CNT_W = $clog2(MAX_VERTS + 1);
  localparam int DEPTH = 2 * MAX_VERTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AXIS_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * COORD_BITS + 1;
  localparam int DOT_W = 2 * COORD_BITS + 2;
  localparam int VERT_W = 2 * COORD_BITS;

  // Cycles from the last projection read until the extremes are settled.
  localparam int DRAIN_CYCLES = 3;
  localparam int DRAIN_W = $clog2(DRAIN_CYCLES);

  // One input item: a vertex routed to one polygon.
  typedef struct packed {
    logic                   shape_select;
    logic signed [IN_W-1:0] vertex_x;
    logic signed [IN_W-1:0] vertex_y;
    logic                   end_of_pair;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic overlaps;
    logic truncated;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_AXIS,
    ST_TEST,
    ST_PROJ0,
    ST_PROJ1,
    ST_DRAIN,
    ST_CHECK,
    ST_RESULT
  } state_t;

  // What a vertex read is for; the tag follows the read down the pipeline.
  typedef enum logic [1:0] {
    RD_EDGE_A,
    RD_EDGE_B,
    RD_PROJ0,
    RD_PROJ1
  } rd_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    rd_kind_t          rd_kind;
    logic              clear_sep;
    logic              proj_init;
    logic              check;
    logic              emit;
    logic              truncated;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic axis_zero;
  } dp_sts_t;

  // Store address of vertex idx of polygon p.
  function automatic logic [ADDR_W-1:0] vert_addr(input logic p,
                                                   input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = p ? ADDR_W'(MAX_VERTS) : ADDR_W'(0);
    return base + ADDR_W'(idx);
  endfunction

  // Takes the low COORD_BITS bits of an input coordinate as a signed value.
  function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [IN_W-1:0] v);
    logic [IN_W+COORD_BITS-1:0] wide;
    wide = (IN_W + COORD_BITS)'(v);
    return wide[COORD_BITS-1:0];
  endfunction

endpackage

[hdl/convex_polygon_sat_overlap.sv]
// Top level of the convex polygon separating-axis overlap block.
// Joins the controller (cpsat_ctrl) and the datapath (cpsat_datapath);
// types come from cpsat_pkg.
//
//   channel   direction  handshake             payload
//   vertex    in         start & !busy         cpsat_pkg::in_item_t
//   result    out        done (one-cycle)      cpsat_pkg::out_item_t
//
// A vertex without end_of_pair is taken and the next item may follow at once.
// An end_of_pair item runs the test: per edge of each polygon with two or more
// vertices, its ends are read and the axis formed; for a nonzero axis each vertex
// of both polygons is read via the single store read port into one serial
// dot-product pipeline, then a drain and a check; last the result is registered.
// Reset is synchronous and clears counts, flags and the sequencer; the store
// needs no clearing. The receiver cannot stall: done is high for one cycle.
module convex_polygon_sat_overlap (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cpsat_pkg::in_item_t  vertex,
  output logic                 busy,
  output logic                 done,
  output cpsat_pkg::out_item_t result
);

  cpsat_pkg::dp_cmd_t cmd;
  cpsat_pkg::dp_sts_t sts;

  cpsat_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .vertex (vertex),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  cpsat_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule

[hdl/cpsat_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cpsat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/cpsat_datapath.sv]
// Datapath of the overlap test: vertex store, edge axis, dot-product
// pipeline, projection extremes and the separation flag.
// Depends on cpsat_pkg and cpsat_ram.
module cpsat_datapath (
  input  logic                clk,
  input  logic                rst,
  input  cpsat_pkg::in_item_t vertex,
  input  cpsat_pkg::dp_cmd_t  cmd,
  output cpsat_pkg::dp_sts_t  sts,
  output cpsat_pkg::out_item_t result
);

  logic [cpsat_pkg::VERT_W-1:0] wdata;
  logic [cpsat_pkg::VERT_W-1:0] rdata;
  logic signed [cpsat_pkg::COORD_BITS-1:0] rd_x;
  logic signed [cpsat_pkg::COORD_BITS-1:0] rd_y;

  // Pipeline tags.
  logic                  s1_valid;
  cpsat_pkg::rd_kind_t   s1_kind;
  logic                  s2_valid;
  logic                  s2_poly;
  logic                  s3_valid;
  logic                  s3_poly;

  // Edge start vertex and current axis.
  logic signed [cpsat_pkg::COORD_BITS-1:0] xa;
  logic signed [cpsat_pkg::COORD_BITS-1:0] ya;
  logic signed [cpsat_pkg::AXIS_W-1:0] ax;
  logic signed [cpsat_pkg::AXIS_W-1:0] ay;

  // Products, dot product and extremes.
  logic signed [cpsat_pkg::PROD_W-1:0] px;
  logic signed [cpsat_pkg::PROD_W-1:0] py;
  logic signed [cpsat_pkg::DOT_W-1:0]  dot;
  logic signed [cpsat_pkg::DOT_W-1:0]  lo0;
  logic signed [cpsat_pkg::DOT_W-1:0]  hi0;
  logic signed [cpsat_pkg::DOT_W-1:0]  lo1;
  logic signed [cpsat_pkg::DOT_W-1:0]  hi1;
  logic                                seen0;
  logic                                seen1;
  logic                                sep;
  logic signed [cpsat_pkg::DOT_W-1:0]  top;
  logic signed [cpsat_pkg::DOT_W-1:0]  bot;

  assign wdata = {cpsat_pkg::to_coord(vertex.vertex_x), cpsat_pkg::to_coord(vertex.vertex_y)};

  cpsat_ram #(
    .WIDTH (cpsat_pkg::VERT_W),
    .DEPTH (cpsat_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  assign rd_x = rdata[cpsat_pkg::VERT_W-1:cpsat_pkg::COORD_BITS];
  assign rd_y = rdata[cpsat_pkg::COORD_BITS-1:0];

  // Overlap interval of the two projections on the current axis.
  always_comb begin
    top = (hi0 < hi1) ? hi0 : hi1;
    bot = (lo0 > lo1) ? lo0 : lo1;
  end

  // Tag pipeline that follows each read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid && (s1_kind == cpsat_pkg::RD_PROJ0 ||
                               s1_kind == cpsat_pkg::RD_PROJ1);
      s3_valid <= s2_valid;
    end
  end

  // Edge vertices, axis and the dot-product stages.
  always_ff @(posedge clk) begin
    s1_kind <= cmd.rd_kind;
    s2_poly <= (s1_kind == cpsat_pkg::RD_PROJ1);
    s3_poly <= s2_poly;
    if (s1_valid && s1_kind == cpsat_pkg::RD_EDGE_A) begin
      xa <= rd_x;
      ya <= rd_y;
    end
    if (s1_valid && s1_kind == cpsat_pkg::RD_EDGE_B) begin
      // Normal of edge (dx, dy) is (dy, -dx).
      ax <= cpsat_pkg::AXIS_W'(rd_y) - cpsat_pkg::AXIS_W'(ya);
      ay <= cpsat_pkg::AXIS_W'(xa) - cpsat_pkg::AXIS_W'(rd_x);
    end
    px  <= cpsat_pkg::PROD_W'(rd_x) * cpsat_pkg::PROD_W'(ax);
    py  <= cpsat_pkg::PROD_W'(rd_y) * cpsat_pkg::PROD_W'(ay);
    dot <= cpsat_pkg::DOT_W'(px) + cpsat_pkg::DOT_W'(py);
  end

  // Projection extremes; an empty polygon stays at the origin.
  always_ff @(posedge clk) begin
    if (cmd.proj_init) begin
      lo0   <= '0;
      hi0   <= '0;
      lo1   <= '0;
      hi1   <= '0;
      seen0 <= 1'b0;
      seen1 <= 1'b0;
    end else if (s3_valid) begin
      if (!s3_poly) begin
        seen0 <= 1'b1;
        if (!seen0 || dot < lo0) begin
          lo0 <= dot;
        end
        if (!seen0 || dot > hi0) begin
          hi0 <= dot;
        end
      end else begin
        seen1 <= 1'b1;
        if (!seen1 || dot < lo1) begin
          lo1 <= dot;
        end
        if (!seen1 || dot > hi1) begin
          hi1 <= dot;
        end
      end
    end
  end

  // Separation flag: set once any axis shows no strict overlap.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_sep) begin
      sep <= 1'b0;
    end else if (cmd.check && top <= bot) begin
      sep <= 1'b1;
    end
  end

  // Result register, loaded as the test ends.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.overlaps  <= ~sep;
      result.truncated <= cmd.truncated;
    end
  end

  assign sts.axis_zero = (ax == '0) && (ay == '0);

endmodule

[hdl/cpsat_ctrl.sv]
// Controller of the overlap test: vertex counts, load routing and the
// sequencer that walks edges and projection reads.
// Depends on cpsat_pkg.
module cpsat_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cpsat_pkg::in_item_t vertex,
  input  cpsat_pkg::dp_sts_t  sts,
  output cpsat_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic                done
);

  cpsat_pkg::state_t state;
  cpsat_pkg::state_t state_next;

  logic [cpsat_pkg::CNT_W-1:0]   first_count;
  logic [cpsat_pkg::CNT_W-1:0]   second_count;
  logic                          overflow_seen;
  logic                          poly;
  logic                          poly_next;
  logic [cpsat_pkg::IDX_W-1:0]   edge_idx;
  logic [cpsat_pkg::IDX_W-1:0]   edge_idx_next;
  logic [cpsat_pkg::IDX_W-1:0]   proj_idx;
  logic [cpsat_pkg::IDX_W-1:0]   proj_idx_next;
  logic [cpsat_pkg::DRAIN_W-1:0] drain_cnt;
  logic [cpsat_pkg::DRAIN_W-1:0] drain_cnt_next;

  logic                          accept;
  logic [cpsat_pkg::CNT_W-1:0]   sel_count;
  logic                          room;
  logic [cpsat_pkg::CNT_W-1:0]   n_cur;
  logic                          edge_last;
  logic [cpsat_pkg::IDX_W-1:0]   edge_j;

  assign busy      = (state != cpsat_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign sel_count = vertex.shape_select ? second_count : first_count;
  assign room      = (sel_count < cpsat_pkg::CNT_W'(cpsat_pkg::MAX_VERTS));
  assign n_cur     = poly ? second_count : first_count;
  assign edge_last = ((cpsat_pkg::CNT_W'(edge_idx) + 1'b1) == n_cur);
  assign edge_j    = edge_last ? '0 : edge_idx + 1'b1;

  // State and sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpsat_pkg::ST_IDLE;
      poly      <= 1'b0;
      edge_idx  <= '0;
      proj_idx  <= '0;
      drain_cnt <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      poly      <= poly_next;
      edge_idx  <= edge_idx_next;
      proj_idx  <= proj_idx_next;
      drain_cnt <= drain_cnt_next;
      done      <= (state == cpsat_pkg::ST_RESULT);
    end
  end

  // Vertex counts and the overflow flag; both clear as a result goes out.
  always_ff @(posedge clk) begin
    if (rst || state == cpsat_pkg::ST_RESULT) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (!room) begin
        overflow_seen <= 1'b1;
      end else if (vertex.shape_select) begin
        second_count <= second_count + 1'b1;
      end else begin
        first_count <= first_count + 1'b1;
      end
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    poly_next      = poly;
    edge_idx_next  = edge_idx;
    proj_idx_next  = proj_idx;
    drain_cnt_next = drain_cnt;

    cmd           = '0;
    cmd.wr_en     = accept && room;
    cmd.wr_addr   = cpsat_pkg::vert_addr(vertex.shape_select,
                                         sel_count[cpsat_pkg::IDX_W-1:0]);
    cmd.rd_kind   = cpsat_pkg::RD_EDGE_A;
    cmd.truncated = overflow_seen;

    case (state)
      cpsat_pkg::ST_IDLE: begin
        if (accept && vertex.end_of_pair) begin
          state_next = cpsat_pkg::ST_START;
        end
      end
      cpsat_pkg::ST_START: begin
        cmd.clear_sep = 1'b1;
        edge_idx_next = '0;
        if (first_count >= cpsat_pkg::CNT_W'(2)) begin
          poly_next  = 1'b0;
          state_next = cpsat_pkg::ST_EDGE_A;
        end else if (second_count >= cpsat_pkg::CNT_W'(2)) begin
          poly_next  = 1'b1;
          state_next = cpsat_pkg::ST_EDGE_A;
        end else begin
          state_next = cpsat_pkg::ST_RESULT;
        end
      end
      cpsat_pkg::ST_EDGE_A: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cpsat_pkg::vert_addr(poly, edge_idx);
        cmd.rd_kind = cpsat_pkg::RD_EDGE_A;
        state_next  = cpsat_pkg::ST_EDGE_B;
      end
      cpsat_pkg::ST_EDGE_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cpsat_pkg::vert_addr(poly, edge_j);
        cmd.rd_kind = cpsat_pkg::RD_EDGE_B;
        state_next  = cpsat_pkg::ST_AXIS;
      end
      cpsat_pkg::ST_AXIS: begin
        state_next = cpsat_pkg::ST_TEST;
      end
      cpsat_pkg::ST_PROJ0: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cpsat_pkg::vert_addr(1'b0, proj_idx);
        cmd.rd_kind = cpsat_pkg::RD_PROJ0;
        if ((cpsat_pkg::CNT_W'(proj_idx) + 1'b1) == first_count) begin
          proj_idx_next  = '0;
          drain_cnt_next = '0;
          state_next     = (second_count != '0) ? cpsat_pkg::ST_PROJ1 : cpsat_pkg::ST_DRAIN;
        end else begin
          proj_idx_next = proj_idx + 1'b1;
        end
      end
      cpsat_pkg::ST_PROJ1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cpsat_pkg::vert_addr(1'b1, proj_idx);
        cmd.rd_kind = cpsat_pkg::RD_PROJ1;
        if ((cpsat_pkg::CNT_W'(proj_idx) + 1'b1) == second_count) begin
          proj_idx_next  = '0;
          drain_cnt_next = '0;
          state_next     = cpsat_pkg::ST_DRAIN;
        end else begin
          proj_idx_next = proj_idx + 1'b1;
        end
      end
      cpsat_pkg::ST_DRAIN: begin
        if (drain_cnt == cpsat_pkg::DRAIN_W'(cpsat_pkg::DRAIN_CYCLES - 1)) begin
          state_next = cpsat_pkg::ST_CHECK;
        end else begin
          drain_cnt_next = drain_cnt + 1'b1;
        end
      end
      cpsat_pkg::ST_TEST, cpsat_pkg::ST_CHECK: begin
        if (state == cpsat_pkg::ST_TEST && !sts.axis_zero) begin
          // Nonzero axis: project both polygons on it.
          cmd.proj_init = 1'b1;
          proj_idx_next = '0;
          state_next    = (first_count != '0) ? cpsat_pkg::ST_PROJ0 : cpsat_pkg::ST_PROJ1;
        end else begin
          // Axis done or skipped: move to the next edge.
          cmd.check = (state == cpsat_pkg::ST_CHECK);
          if (!edge_last) begin
            edge_idx_next = edge_idx + 1'b1;
            state_next    = cpsat_pkg::ST_EDGE_A;
          end else if (!poly && second_count >= cpsat_pkg::CNT_W'(2)) begin
            poly_next     = 1'b1;
            edge_idx_next = '0;
            state_next    = cpsat_pkg::ST_EDGE_A;
          end else begin
            state_next = cpsat_pkg::ST_RESULT;
          end
        end
      end
      cpsat_pkg::ST_RESULT: begin
        cmd.emit   = 1'b1;
        state_next = cpsat_pkg::ST_IDLE;
      end
      default: begin
        state_next = cpsat_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The block goes idle only together with its result strobe.
  a_idle_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  // A result is a single-cycle strobe.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // Counts never pass capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    first_count <= cpsat_pkg::CNT_W'(cpsat_pkg::MAX_VERTS) &&
    second_count <= cpsat_pkg::CNT_W'(cpsat_pkg::MAX_VERTS))
    else $error("vertex count above capacity");

  // A test starts only after an accepted end-of-pair item.
  a_start_cause: assert property (@(posedge clk) disable iff (rst)
    (state == cpsat_pkg::ST_START) |-> $past(accept && vertex.end_of_pair))
    else $error("test started without an end-of-pair item");
`endif

endmodule
